### hdl/crg_pkg.sv
`timescale 1ns / 1ps

package crg_pkg;

    // Values carried on s_axis_tuser.
    localparam logic MODE_START   = 1'b0;
    localparam logic MODE_ADVANCE = 1'b1;

    // Pixel slot numbers within one run.
    localparam logic [2:0] SLOT_FIRST      = 3'd0;
    localparam logic [2:0] SLOT_LAST_START = 3'd1;
    localparam logic [2:0] SLOT_LAST_ADV   = 3'd7;

    // Decision variable constants of the midpoint recurrence.
    localparam int DEC_INIT     = 3;
    localparam int DEC_INC_KEEP = 6;
    localparam int DEC_INC_DIAG = 10;

    // How one of the eight symmetric pixels is formed from (x, y).
    typedef struct packed {
        logic swap;   // use (y, x) instead of (x, y)
        logic neg_x;  // subtract the x offset from the center
        logic neg_y;  // subtract the y offset from the center
    } oct_sel_t;

    // Slot order: (+x,+y) (+y,+x) (+y,-x) (+x,-y) (-x,-y) (-y,-x) (-y,+x) (-x,+y)
    function automatic oct_sel_t oct_sel(input logic [2:0] slot);
        oct_sel_t sel;
        sel.swap  = slot[0] ^ slot[1];
        sel.neg_x = slot[2];
        sel.neg_y = slot[2] ^ slot[1];
        return sel;
    endfunction

endpackage

### hdl/circle_raster_generator.sv
`timescale 1ns / 1ps

// Midpoint (Bresenham) circle rasterizer with stream interfaces.
//
// Input beats carry a mode on s_axis_tuser: a start beat latches center and
// radius and yields two pixels (the center, then the top point); an advance
// beat takes one octant step and yields the eight symmetric pixels of the new
// octant point. An advance while no circle is running yields nothing.
// Output beats carry pixel_x and pixel_y on m_axis_tdata, last_of_run on
// m_axis_tlast and circle_done on m_axis_tuser.
//
// The circle state is updated at the clock edge where a beat is accepted. A
// run counter then walks the pixel slots, one per cycle while the output
// register can load, into the output register, so the first pixel of a beat
// reaches m_axis through the run registers and then the output register.
// Unstalled, the output runs one pixel per cycle: eight for an advance, two
// for a start, none for an idle advance. The next input beat is taken in the
// same cycle the last pixel of the current run enters the output register, so runs follow each other without gaps.
// When m_axis_tready is low the output register holds its pixel, the run
// counter stops and s_axis_tready drops once the run cannot finish.
// Synchronous reset (aresetn low) empties the output register, drops any run
// in progress and returns to idle with center, octant point and decision zero.

module circle_raster_generator #(
    parameter int COORD_BITS  = 12,
    parameter int RADIUS_BITS = 10
) (
    input  logic                          aclk,
    input  logic                          aresetn,

    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // center_x [COORD_BITS-1:0], center_y, radius, zero padding to bytes.
    input  logic [((2*COORD_BITS+RADIUS_BITS+7)/8)*8-1:0] s_axis_tdata,
    // mode
    input  logic                          s_axis_tuser,

    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // pixel_x [COORD_BITS:0], pixel_y, zero padding to bytes.
    output logic [((2*COORD_BITS+2+7)/8)*8-1:0] m_axis_tdata,
    // last_of_run
    output logic                          m_axis_tlast,
    // circle_done
    output logic                          m_axis_tuser
);

    import crg_pkg::*;

    localparam int IN_BITS  = 2*COORD_BITS + RADIUS_BITS;
    localparam int PIX_W    = COORD_BITS + 1;
    localparam int OUT_W    = ((2*PIX_W + 7) / 8) * 8;
    localparam int XY_W     = RADIUS_BITS + 2;   // octant point, y may reach -1
    localparam int DEC_W    = RADIUS_BITS + 4;   // decision stays within about 4r
    localparam int SUM_W    = ((COORD_BITS > XY_W) ? COORD_BITS : XY_W) + 2;

    // Input field unpacking.
    logic signed [COORD_BITS-1:0]  in_cx;
    logic signed [COORD_BITS-1:0]  in_cy;
    logic        [RADIUS_BITS-1:0] in_radius;

    assign in_cx     = s_axis_tdata[COORD_BITS-1:0];
    assign in_cy     = s_axis_tdata[2*COORD_BITS-1:COORD_BITS];
    assign in_radius = s_axis_tdata[IN_BITS-1:2*COORD_BITS];

    // Circle state.
    logic signed [COORD_BITS-1:0] cx_reg, cx_next;
    logic signed [COORD_BITS-1:0] cy_reg, cy_next;
    logic signed [XY_W-1:0]       ox_reg, ox_next;
    logic signed [XY_W-1:0]       oy_reg, oy_next;
    logic signed [DEC_W-1:0]      dec_reg, dec_next;
    logic                         active_reg, active_next;

    // Pixel run in progress.
    logic       run_valid_reg, run_valid_next;
    logic       run_start_reg, run_start_next;
    logic       run_done_reg, run_done_next;
    logic [2:0] run_slot_reg, run_slot_next;

    // Output register.
    logic                    out_valid_reg, out_valid_next;
    logic signed [PIX_W-1:0] out_px_reg, out_px_next;
    logic signed [PIX_W-1:0] out_py_reg, out_py_next;
    logic                    out_last_reg, out_last_next;
    logic                    out_done_reg, out_done_next;

    logic out_load;
    logic run_fire;
    logic run_end;
    logic in_accept;

    assign out_load  = !out_valid_reg || m_axis_tready;
    assign run_fire  = run_valid_reg && out_load;
    assign run_end   = run_fire &&
                       (run_slot_reg == (run_start_reg ? SLOT_LAST_START : SLOT_LAST_ADV));
    assign s_axis_tready = !run_valid_reg || run_end;
    assign in_accept = s_axis_tvalid && s_axis_tready;

    // One octant step, computed from the pre-step point.
    logic signed [DEC_W-1:0] ox_ext, oy_ext;
    logic signed [DEC_W-1:0] dec_step;
    logic signed [XY_W-1:0]  step_x, step_y;
    logic                    step_done;
    logic signed [DEC_W-1:0] dec_start;

    always_comb begin
        ox_ext = DEC_W'(ox_reg);
        oy_ext = DEC_W'(oy_reg);
        step_x = ox_reg + XY_W'(1);
        if (dec_reg < 0) begin
            dec_step = dec_reg + (ox_ext <<< 2) + DEC_W'(DEC_INC_KEEP);
            step_y   = oy_reg;
        end else begin
            dec_step = dec_reg + ((ox_ext - oy_ext) <<< 2) + DEC_W'(DEC_INC_DIAG);
            step_y   = oy_reg - XY_W'(1);
        end
        step_done = step_x > step_y;
        dec_start = DEC_W'(DEC_INIT) - (DEC_W'(in_radius) <<< 1);
    end

    // State and run control.
    always_comb begin
        cx_next        = cx_reg;
        cy_next        = cy_reg;
        ox_next        = ox_reg;
        oy_next        = oy_reg;
        dec_next       = dec_reg;
        active_next    = active_reg;
        run_valid_next = run_valid_reg;
        run_start_next = run_start_reg;
        run_done_next  = run_done_reg;
        run_slot_next  = run_slot_reg;

        if (run_fire) begin
            run_slot_next = run_slot_reg + 3'd1;
        end
        if (run_end) begin
            run_valid_next = 1'b0;
        end

        if (in_accept) begin
            if (s_axis_tuser == MODE_START) begin
                cx_next        = in_cx;
                cy_next        = in_cy;
                ox_next        = '0;
                oy_next        = XY_W'(in_radius);
                dec_next       = dec_start;
                active_next    = 1'b1;
                run_valid_next = 1'b1;
                run_start_next = 1'b1;
                run_done_next  = 1'b0;
                run_slot_next  = SLOT_FIRST;
            end else if (active_reg) begin
                ox_next        = step_x;
                oy_next        = step_y;
                dec_next       = dec_step;
                active_next    = !step_done;
                run_valid_next = 1'b1;
                run_start_next = 1'b0;
                run_done_next  = step_done;
                run_slot_next  = SLOT_FIRST;
            end
        end
    end

    // Pixel for the current slot. A start run never swaps the offsets: its
    // center pixel uses zero offsets and its top pixel is slot one with
    // x = 0 and y = r.
    oct_sel_t                sel;
    logic                    zero_off;
    logic                    swap_xy;
    logic signed [SUM_W-1:0] off_x, off_y;
    logic signed [SUM_W-1:0] sum_x, sum_y;

    always_comb begin
        sel      = oct_sel(run_slot_reg);
        zero_off = run_start_reg && (run_slot_reg == SLOT_FIRST);
        swap_xy  = sel.swap && !run_start_reg;
        off_x    = swap_xy ? SUM_W'(oy_reg) : SUM_W'(ox_reg);
        off_y    = swap_xy ? SUM_W'(ox_reg) : SUM_W'(oy_reg);
        if (zero_off) begin
            off_x = '0;
            off_y = '0;
        end
        sum_x = sel.neg_x ? (SUM_W'(cx_reg) - off_x) : (SUM_W'(cx_reg) + off_x);
        sum_y = sel.neg_y ? (SUM_W'(cy_reg) - off_y) : (SUM_W'(cy_reg) + off_y);
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        out_px_next    = out_px_reg;
        out_py_next    = out_py_reg;
        out_last_next  = out_last_reg;
        out_done_next  = out_done_reg;
        if (out_load) begin
            out_valid_next = run_valid_reg;
            out_px_next    = sum_x[PIX_W-1:0];
            out_py_next    = sum_y[PIX_W-1:0];
            out_last_next  = run_end;
            out_done_next  = run_end && run_done_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cx_reg        <= '0;
            cy_reg        <= '0;
            ox_reg        <= '0;
            oy_reg        <= '0;
            dec_reg       <= '0;
            active_reg    <= 1'b0;
            run_valid_reg <= 1'b0;
            run_start_reg <= 1'b0;
            run_done_reg  <= 1'b0;
            run_slot_reg  <= SLOT_FIRST;
            out_valid_reg <= 1'b0;
        end else begin
            cx_reg        <= cx_next;
            cy_reg        <= cy_next;
            ox_reg        <= ox_next;
            oy_reg        <= oy_next;
            dec_reg       <= dec_next;
            active_reg    <= active_next;
            run_valid_reg <= run_valid_next;
            run_start_reg <= run_start_next;
            run_done_reg  <= run_done_next;
            run_slot_reg  <= run_slot_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Output payload needs no reset.
    always_ff @(posedge aclk) begin
        out_px_reg   <= out_px_next;
        out_py_reg   <= out_py_next;
        out_last_reg <= out_last_next;
        out_done_reg <= out_done_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = OUT_W'({out_py_reg, out_px_reg});
    assign m_axis_tlast  = out_last_reg;
    assign m_axis_tuser  = out_done_reg;

endmodule
